>>> rtl/core/pso_pkg.sv
// Shared types and constants for the particle swarm update pipeline.
// Used by the pull unit, the top level and the testbench.
package pso_pkg;

  // Gains are unsigned Q4.12, random fractions unsigned Q0.16
  localparam int GAIN_BITS      = 16;
  localparam int GAIN_FRAC_BITS = 12;
  localparam int RAND_BITS      = 16;

  localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd8192;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  // Register stages from request to result register
  localparam int STAGES = 7;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_GAIN_PERSONAL = 2'd0,
    CFG_GAIN_GLOBAL   = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    HIT_NONE  = 2'd0,
    HIT_UPPER = 2'd1,
    HIT_LOWER = 2'd2
  } hit_t;

endpackage

>>> rtl/core/pso_in_if.sv
// Request channel of the particle update: valid/ready plus one variable's data.
// Depends on nothing but its own width parameter.
interface pso_in_if #(
  parameter int DATA_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic signed [DATA_BITS-1:0] position;
  logic signed [DATA_BITS-1:0] velocity;
  logic signed [DATA_BITS-1:0] personal_best;
  logic signed [DATA_BITS-1:0] global_best;
  logic [15:0]                 rand_one;
  logic [15:0]                 rand_two;
  logic signed [DATA_BITS-1:0] lower_limit;
  logic signed [DATA_BITS-1:0] upper_limit;
  logic [DATA_BITS-2:0]        speed_limit;
  logic                        last_item;

  modport source (
    output valid, position, velocity, personal_best, global_best,
           rand_one, rand_two, lower_limit, upper_limit, speed_limit, last_item,
    input  ready
  );

  modport sink (
    input  valid, position, velocity, personal_best, global_best,
           rand_one, rand_two, lower_limit, upper_limit, speed_limit, last_item,
    output ready
  );
endinterface

>>> rtl/core/pso_out_if.sv
// Result channel of the particle update: valid/ready plus the updated variable.
// Depends on nothing but its own width parameter.
interface pso_out_if #(
  parameter int DATA_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic signed [DATA_BITS-1:0] new_position;
  logic signed [DATA_BITS-1:0] new_velocity;
  logic                        speed_clamped;
  logic [1:0]                  bound_hit;
  logic                        last_out;

  modport source (
    output valid, new_position, new_velocity, speed_clamped, bound_hit, last_out,
    input  ready
  );

  modport sink (
    input  valid, new_position, new_velocity, speed_clamped, bound_hit, last_out,
    output ready
  );
endinterface

>>> rtl/core/pso_pull.sv
// One pull term: registered product of difference and Q4.12 coefficient,
// then floor shift by the gain fraction and saturation. Uses pso_pkg.
module pso_pull #(
  parameter int DATA_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 load,
  input  logic signed [DATA_BITS-1:0]          diff,
  input  logic [pso_pkg::GAIN_BITS-1:0]        coef,
  output logic signed [DATA_BITS-1:0]          pull
);

  localparam int PW = DATA_BITS + pso_pkg::GAIN_BITS + 1;
  localparam int QW = PW - pso_pkg::GAIN_FRAC_BITS;

  logic signed [PW-1:0] prod_r;
  logic signed [QW-1:0] quot;
  logic [QW-DATA_BITS:0] top_bits;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= diff * $signed({1'b0, coef});
    end
  end

  // Dropping the low bits of a signed product is a floor division
  assign quot     = prod_r[PW-1:pso_pkg::GAIN_FRAC_BITS];
  assign top_bits = quot[QW-1:DATA_BITS-1];

  always_comb begin
    if ((&top_bits) || !(|top_bits)) begin
      pull = quot[DATA_BITS-1:0];
    end else if (quot[QW-1]) begin
      pull = {1'b1, {(DATA_BITS-1){1'b0}}};
    end else begin
      pull = {1'b0, {(DATA_BITS-1){1'b1}}};
    end
  end

endmodule

>>> rtl/core/pso_particle_update.sv
// Particle swarm velocity and position update, one variable per request.
// A request passes through seven register stages, stage 0 to the output register.
// Throughput: one request per cycle while out_res is ready; the two Q4.12 pull
// multipliers set the stage cut. A stage stalls only when it and every later stage
// hold items, so empty stages keep filling while out_res waits.
// Reset clears all stage valid bits and sets both gains to 2.0 (8192).
// Uses pso_pkg, pso_in_if, pso_out_if and pso_pull.
module pso_particle_update #(
  parameter int DATA_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  pso_in_if.sink                                in_req,
  pso_out_if.source                             out_res,
  input  logic                                  cfg_we,
  input  logic [pso_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [pso_pkg::CFG_DATA_BITS-1:0]     cfg_wdata
);

  localparam int N  = DATA_BITS;
  localparam int GB = pso_pkg::GAIN_BITS;
  localparam int ST = pso_pkg::STAGES;
  localparam logic signed [N-1:0] DMAX = {1'b0, {(N-1){1'b1}}};
  localparam logic signed [N-1:0] DMIN = {1'b1, {(N-1){1'b0}}};

  function automatic logic signed [N-1:0] sat_add(input logic signed [N-1:0] a,
                                                  input logic signed [N-1:0] b);
    logic [N:0] s;
    s = {a[N-1], a} + {b[N-1], b};
    if (s[N] != s[N-1]) begin
      sat_add = s[N] ? DMIN : DMAX;
    end else begin
      sat_add = s[N-1:0];
    end
  endfunction

  function automatic logic signed [N-1:0] sat_sub(input logic signed [N-1:0] a,
                                                  input logic signed [N-1:0] b);
    logic [N:0] s;
    s = {a[N-1], a} - {b[N-1], b};
    if (s[N] != s[N-1]) begin
      sat_sub = s[N] ? DMIN : DMAX;
    end else begin
      sat_sub = s[N-1:0];
    end
  endfunction

  // Configuration
  logic [GB-1:0] gain_personal_r;
  logic [GB-1:0] gain_global_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_personal_r <= pso_pkg::GAIN_RESET;
      gain_global_r   <= pso_pkg::GAIN_RESET;
    end else if (cfg_we) begin
      unique case (pso_pkg::cfg_reg_t'(cfg_index))
        pso_pkg::CFG_GAIN_PERSONAL: gain_personal_r <= cfg_wdata[GB-1:0];
        pso_pkg::CFG_GAIN_GLOBAL:   gain_global_r   <= cfg_wdata[GB-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control
  logic [ST-1:0] vld_r;
  logic [ST-1:0] en;

  always_comb begin
    en[ST-1] = !vld_r[ST-1] || out_res.ready;
    for (int k = ST - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_req.valid;
      end
      for (int k = 1; k < ST; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign in_req.ready = en[0];

  // Stage 0: coefficients and differences
  logic [2*GB-1:0]        cp_full;
  logic [2*GB-1:0]        cg_full;
  logic [GB-1:0]          s0_c1_r, s0_c2_r;
  logic signed [N-1:0]    s0_d1_r, s0_d2_r, s0_pos_r, s0_vel_r, s0_lower_r, s0_upper_r;
  logic [N-2:0]           s0_vlim_r;
  logic                   s0_last_r;

  assign cp_full = gain_personal_r * in_req.rand_one;
  assign cg_full = gain_global_r * in_req.rand_two;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_c1_r    <= cp_full[2*GB-1:GB];
      s0_c2_r    <= cg_full[2*GB-1:GB];
      s0_d1_r    <= sat_sub(in_req.personal_best, in_req.position);
      s0_d2_r    <= sat_sub(in_req.global_best, in_req.position);
      s0_pos_r   <= in_req.position;
      s0_vel_r   <= in_req.velocity;
      s0_lower_r <= in_req.lower_limit;
      s0_upper_r <= in_req.upper_limit;
      s0_vlim_r  <= in_req.speed_limit;
      s0_last_r  <= in_req.last_item;
    end
  end

  // Stage 1: products live inside the pull units
  logic signed [N-1:0] pull_personal, pull_global;
  logic signed [N-1:0] s1_pos_r, s1_vel_r, s1_lower_r, s1_upper_r;
  logic [N-2:0]        s1_vlim_r;
  logic                s1_last_r;

  pso_pull #(.DATA_BITS(N)) u_pull_personal (
    .clk  (clk),
    .load (en[1]),
    .diff (s0_d1_r),
    .coef (s0_c1_r),
    .pull (pull_personal)
  );

  pso_pull #(.DATA_BITS(N)) u_pull_global (
    .clk  (clk),
    .load (en[1]),
    .diff (s0_d2_r),
    .coef (s0_c2_r),
    .pull (pull_global)
  );

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_pos_r   <= s0_pos_r;
      s1_vel_r   <= s0_vel_r;
      s1_lower_r <= s0_lower_r;
      s1_upper_r <= s0_upper_r;
      s1_vlim_r  <= s0_vlim_r;
      s1_last_r  <= s0_last_r;
    end
  end

  // Stage 2: first velocity sum
  logic signed [N-1:0] s2_v1_r, s2_pull2_r, s2_pos_r, s2_lower_r, s2_upper_r;
  logic [N-2:0]        s2_vlim_r;
  logic                s2_last_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_v1_r    <= sat_add(s1_vel_r, pull_personal);
      s2_pull2_r <= pull_global;
      s2_pos_r   <= s1_pos_r;
      s2_lower_r <= s1_lower_r;
      s2_upper_r <= s1_upper_r;
      s2_vlim_r  <= s1_vlim_r;
      s2_last_r  <= s1_last_r;
    end
  end

  // Stage 3: second sum and speed clamp
  logic signed [N-1:0] v2, lim_pos, lim_neg, v_clamp;
  logic                clamp_hit;
  logic signed [N-1:0] s3_v_r, s3_pos_r, s3_lower_r, s3_upper_r;
  logic [N-2:0]        s3_vlim_r;
  logic                s3_clamped_r, s3_last_r;

  assign v2      = sat_add(s2_v1_r, s2_pull2_r);
  assign lim_pos = $signed({1'b0, s2_vlim_r});
  assign lim_neg = -lim_pos;

  always_comb begin
    if (v2 < lim_neg) begin
      v_clamp   = lim_neg;
      clamp_hit = 1'b1;
    end else if (v2 > lim_pos) begin
      v_clamp   = lim_pos;
      clamp_hit = 1'b1;
    end else begin
      v_clamp   = v2;
      clamp_hit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_v_r       <= v_clamp;
      s3_clamped_r <= clamp_hit;
      s3_vlim_r    <= s2_vlim_r;
      s3_pos_r     <= s2_pos_r;
      s3_lower_r   <= s2_lower_r;
      s3_upper_r   <= s2_upper_r;
      s3_last_r    <= s2_last_r;
    end
  end

  // Stage 4: position step
  logic signed [N-1:0] s4_p_r, s4_v_r, s4_lower_r, s4_upper_r;
  logic                s4_clamped_r, s4_last_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_p_r       <= sat_add(s3_pos_r, s3_v_r);
      s4_v_r       <= s3_v_r;
      s4_lower_r   <= s3_lower_r;
      s4_upper_r   <= s3_upper_r;
      s4_clamped_r <= s3_clamped_r;
      s4_last_r    <= s3_last_r;
    end
  end

  // Stage 5: bound test, halved overshoot, reversed velocity
  pso_pkg::hit_t       hit_nxt;
  logic signed [N-1:0] ov_nxt, bound_nxt, v_nxt;
  pso_pkg::hit_t       s5_hit_r;
  logic signed [N-1:0] s5_ov_r, s5_bound_r, s5_p_r, s5_v_r;
  logic                s5_clamped_r, s5_last_r;

  always_comb begin
    priority if (s4_p_r > s4_upper_r) begin
      hit_nxt   = pso_pkg::HIT_UPPER;
      ov_nxt    = sat_sub(s4_p_r, s4_upper_r) >>> 1;
      bound_nxt = s4_upper_r;
      v_nxt     = -(s4_v_r >>> 1);
    end else if (s4_p_r < s4_lower_r) begin
      hit_nxt   = pso_pkg::HIT_LOWER;
      ov_nxt    = sat_sub(s4_lower_r, s4_p_r) >>> 1;
      bound_nxt = s4_lower_r;
      v_nxt     = -(s4_v_r >>> 1);
    end else begin
      hit_nxt   = pso_pkg::HIT_NONE;
      ov_nxt    = '0;
      bound_nxt = s4_upper_r;
      v_nxt     = s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_hit_r     <= hit_nxt;
      s5_ov_r      <= ov_nxt;
      s5_bound_r   <= bound_nxt;
      s5_p_r       <= s4_p_r;
      s5_v_r       <= v_nxt;
      s5_clamped_r <= s4_clamped_r;
      s5_last_r    <= s4_last_r;
    end
  end

  // Stage 6: reflected position into the result register
  logic signed [N-1:0] p_nxt;
  pso_pkg::hit_t       s6_hit_r;
  logic signed [N-1:0] s6_p_r, s6_v_r;
  logic                s6_clamped_r, s6_last_r;

  always_comb begin
    unique case (s5_hit_r)
      pso_pkg::HIT_UPPER: p_nxt = sat_sub(s5_bound_r, s5_ov_r);
      pso_pkg::HIT_LOWER: p_nxt = sat_add(s5_bound_r, s5_ov_r);
      default:            p_nxt = s5_p_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_hit_r     <= s5_hit_r;
      s6_p_r       <= p_nxt;
      s6_v_r       <= s5_v_r;
      s6_clamped_r <= s5_clamped_r;
      s6_last_r    <= s5_last_r;
    end
  end

  assign out_res.valid         = vld_r[ST-1];
  assign out_res.new_position  = s6_p_r;
  assign out_res.new_velocity  = s6_v_r;
  assign out_res.speed_clamped = s6_clamped_r;
  assign out_res.bound_hit     = s6_hit_r;
  assign out_res.last_out      = s6_last_r;

`ifndef SYNTH
  // A clamped velocity sits exactly on one edge of the speed limit
  a_clamp_on_edge: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[3] && s3_clamped_r) |->
      (s3_v_r == $signed({1'b0, s3_vlim_r}) || s3_v_r == -$signed({1'b0, s3_vlim_r})))
    else $error("clamped velocity off the speed limit");

  // An empty result register must let requests in
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[ST-1] |-> in_req.ready)
    else $error("request blocked with empty result register");

  // Items in flight change only by accepted requests and delivered results
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |->
      ($countones(vld_r) == $countones($past(vld_r))
        + $past(in_req.valid && in_req.ready) - $past(out_res.valid && out_res.ready)))
    else $error("item lost or duplicated in pipeline");
`endif

endmodule

>>> tb/sv/tb_pso_particle_update.sv
// Self-checking testbench for the particle swarm velocity/position update block.
// Needs pso_pkg, pso_in_if, pso_out_if and pso_particle_update from the RTL tree.
module tb_pso_particle_update;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_BITS    = 32;
  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 6;
  localparam int HOLD_CYCLES  = 64;
  localparam int CYCLE_LIMIT  = 100000;

  localparam logic signed [DATA_BITS-1:0] DMAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_BITS-1:0] DMIN = 32'sh8000_0000;
  localparam logic signed [DATA_BITS-1:0] ONE  = 32'sh0001_0000;
  localparam logic signed [DATA_BITS-1:0] SPEED_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    logic signed [DATA_BITS-1:0]   position;
    logic signed [DATA_BITS-1:0]   velocity;
    logic signed [DATA_BITS-1:0]   personal_best;
    logic signed [DATA_BITS-1:0]   global_best;
    logic [pso_pkg::RAND_BITS-1:0] rand_one;
    logic [pso_pkg::RAND_BITS-1:0] rand_two;
    logic signed [DATA_BITS-1:0]   lower_limit;
    logic signed [DATA_BITS-1:0]   upper_limit;
    logic [DATA_BITS-2:0]          speed_limit;
    logic                          last_item;
  } pso_request_t;

  typedef struct {
    logic signed [DATA_BITS-1:0] new_position;
    logic signed [DATA_BITS-1:0] new_velocity;
    logic                        speed_clamped;
    pso_pkg::hit_t               bound_hit;
    logic                        last_out;
  } pso_result_t;

  class particle_update_ledger;
    localparam longint DATA_HI = 64'sd2147483647;
    localparam longint DATA_LO = -64'sd2147483648;

    logic [pso_pkg::GAIN_BITS-1:0] gain_personal;
    logic [pso_pkg::GAIN_BITS-1:0] gain_global;
    pso_result_t                   expected_updates[$];
    int                            errors;

    function new();
      gain_personal = pso_pkg::GAIN_RESET;
      gain_global   = pso_pkg::GAIN_RESET;
      errors        = 0;
    endfunction

    function void set_gain(pso_pkg::cfg_reg_t index, logic [pso_pkg::GAIN_BITS-1:0] value);
      case (index)
        pso_pkg::CFG_GAIN_PERSONAL: gain_personal = value;
        pso_pkg::CFG_GAIN_GLOBAL:   gain_global   = value;
        default: ;
      endcase
    endfunction

    function longint clip(longint x);
      if (x > DATA_HI) return DATA_HI;
      if (x < DATA_LO) return DATA_LO;
      return x;
    endfunction

    // floor(diff * (gain*frac >> 16) / 4096), saturated
    function longint pull_term(longint diff, logic [pso_pkg::GAIN_BITS-1:0] gain,
                               logic [pso_pkg::RAND_BITS-1:0] frac);
      logic [31:0] prod;
      longint      coef;
      prod = {16'd0, gain} * {16'd0, frac};
      coef = longint'(prod >> pso_pkg::RAND_BITS);
      return clip((diff * coef) >>> pso_pkg::GAIN_FRAC_BITS);
    endfunction

    function pso_result_t predict_update(pso_request_t r);
      longint      pos, vel, lim, lower, upper, p;
      pso_result_t res;
      pos   = longint'(r.position);
      lower = longint'(r.lower_limit);
      upper = longint'(r.upper_limit);
      lim   = longint'({1'b0, r.speed_limit});
      vel = clip(longint'(r.velocity)
                 + pull_term(clip(longint'(r.personal_best) - pos), gain_personal, r.rand_one));
      vel = clip(vel
                 + pull_term(clip(longint'(r.global_best) - pos), gain_global, r.rand_two));
      res.speed_clamped = 1'b0;
      res.bound_hit     = pso_pkg::HIT_NONE;
      if (vel < -lim) begin
        vel = -lim;
        res.speed_clamped = 1'b1;
      end else if (vel > lim) begin
        vel = lim;
        res.speed_clamped = 1'b1;
      end
      p = clip(pos + vel);
      // upper test wins; no second reflection even if it lands past the lower bound
      if (p > upper) begin
        p = clip(upper - (clip(p - upper) >>> 1));
        vel = -(vel >>> 1);
        res.bound_hit = pso_pkg::HIT_UPPER;
      end else if (p < lower) begin
        p = clip(lower + (clip(lower - p) >>> 1));
        vel = -(vel >>> 1);
        res.bound_hit = pso_pkg::HIT_LOWER;
      end
      res.new_position = p[DATA_BITS-1:0];
      res.new_velocity = vel[DATA_BITS-1:0];
      res.last_out     = r.last_item;
      return res;
    endfunction

    function void note_request(pso_request_t r);
      expected_updates.insert(expected_updates.size(), predict_update(r));
    endfunction

    function void check_result(pso_result_t got);
      pso_result_t want;
      if (expected_updates.size() == 0) begin
        $display("%0t: result with no request pending: position %h velocity %h",
                 $time, got.new_position, got.new_velocity);
        errors++;
        return;
      end
      want = expected_updates.pop_front();
      if (got.new_position !== want.new_position) begin
        $display("%0t: new_position expected %h actual %h",
                 $time, want.new_position, got.new_position);
        errors++;
      end
      if (got.new_velocity !== want.new_velocity) begin
        $display("%0t: new_velocity expected %h actual %h",
                 $time, want.new_velocity, got.new_velocity);
        errors++;
      end
      if (got.speed_clamped !== want.speed_clamped) begin
        $display("%0t: speed_clamped expected %b actual %b",
                 $time, want.speed_clamped, got.speed_clamped);
        errors++;
      end
      if (got.bound_hit !== want.bound_hit) begin
        $display("%0t: bound_hit expected %0d actual %0d",
                 $time, want.bound_hit, got.bound_hit);
        errors++;
      end
      if (got.last_out !== want.last_out) begin
        $display("%0t: last_out expected %b actual %b",
                 $time, want.last_out, got.last_out);
        errors++;
      end
    endfunction

    function int pending_count();
      return expected_updates.size();
    endfunction
  endclass

  logic                               clk = 1'b0;
  logic                               rst_n;
  logic                               cfg_we;
  logic [pso_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [pso_pkg::CFG_DATA_BITS-1:0]  cfg_wdata;
  bit                                 calm;
  bit                                 hold_due;

  int phase_personal[7] = '{8192, 0, 65535, 65535, 0, -1, 4096};
  int phase_social[7]   = '{8192, 0, 65535, 0, 65535, -1, 12288};
  int phase_items[7]    = '{250, 200, 250, 150, 150, 250, 200};

  particle_update_ledger ledger = new();

  pso_in_if  #(.DATA_BITS(DATA_BITS)) in_req ();
  pso_out_if #(.DATA_BITS(DATA_BITS)) out_res ();

  pso_particle_update #(.DATA_BITS(DATA_BITS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic pso_request_t make_request(
    logic signed [DATA_BITS-1:0] position, logic signed [DATA_BITS-1:0] velocity,
    logic signed [DATA_BITS-1:0] personal_best, logic signed [DATA_BITS-1:0] global_best,
    logic [pso_pkg::RAND_BITS-1:0] rand_one, logic [pso_pkg::RAND_BITS-1:0] rand_two,
    logic signed [DATA_BITS-1:0] lower_limit, logic signed [DATA_BITS-1:0] upper_limit,
    logic signed [DATA_BITS-1:0] speed_word, logic last_item);
    pso_request_t r;
    r.position      = position;
    r.velocity      = velocity;
    r.personal_best = personal_best;
    r.global_best   = global_best;
    r.rand_one      = rand_one;
    r.rand_two      = rand_two;
    r.lower_limit   = lower_limit;
    r.upper_limit   = upper_limit;
    r.speed_limit   = speed_word[DATA_BITS-2:0];
    r.last_item     = last_item;
    return r;
  endfunction

  function automatic logic signed [DATA_BITS-1:0] extreme_word();
    case ($urandom_range(0, 5))
      0:       return DMAX;
      1:       return DMIN;
      2:       return 0;
      3:       return -1;
      4:       return 1;
      default: return $urandom;
    endcase
  endfunction

  function automatic pso_request_t random_request();
    pso_request_t               r;
    int                         shape;
    logic signed [DATA_BITS-1:0] center;
    logic signed [DATA_BITS-1:0] span;
    shape       = $urandom_range(0, 9);
    r.rand_one  = 16'($urandom);
    r.rand_two  = 16'($urandom);
    r.last_item = ($urandom_range(0, 15) == 0);
    if (shape < 7) begin
      // plausible particle: bounds around a center, position near or past them
      center = $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
      span   = $urandom_range(1, 32'h0040_0000);
      r.lower_limit   = center - span;
      r.upper_limit   = center + span;
      r.position      = r.lower_limit - span / 2 + $urandom_range(0, 3 * span);
      r.velocity      = $urandom_range(0, 2 * span) - span;
      r.personal_best = r.lower_limit + $urandom_range(0, 2 * span);
      r.global_best   = r.lower_limit + $urandom_range(0, 2 * span);
      r.speed_limit   = ($urandom_range(0, 7) == 0) ? '0 : 31'($urandom_range(0, span));
    end else if (shape < 9) begin
      r.position      = $urandom;
      r.velocity      = $urandom;
      r.personal_best = $urandom;
      r.global_best   = $urandom;
      r.lower_limit   = $urandom;
      r.upper_limit   = $urandom;
      r.speed_limit   = 31'($urandom);
    end else begin
      r.position      = extreme_word();
      r.velocity      = extreme_word();
      r.personal_best = extreme_word();
      r.global_best   = extreme_word();
      r.lower_limit   = extreme_word();
      r.upper_limit   = extreme_word();
      r.speed_limit   = 31'(extreme_word());
      r.rand_one      = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      r.rand_two      = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    end
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input pso_request_t r);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_req.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_req.valid         <= 1'b1;
    in_req.position      <= r.position;
    in_req.velocity      <= r.velocity;
    in_req.personal_best <= r.personal_best;
    in_req.global_best   <= r.global_best;
    in_req.rand_one      <= r.rand_one;
    in_req.rand_two      <= r.rand_two;
    in_req.lower_limit   <= r.lower_limit;
    in_req.upper_limit   <= r.upper_limit;
    in_req.speed_limit   <= r.speed_limit;
    in_req.last_item     <= r.last_item;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_req.valid <= 1'b0;
    while (ledger.pending_count() != 0) @(negedge clk);
  endtask

  task automatic write_gains(input logic [pso_pkg::GAIN_BITS-1:0] personal_gain,
                             input logic [pso_pkg::GAIN_BITS-1:0] social_gain);
    cfg_we    <= 1'b1;
    cfg_index <= pso_pkg::CFG_GAIN_PERSONAL;
    cfg_wdata <= personal_gain;
    @(negedge clk);
    cfg_index <= pso_pkg::CFG_GAIN_GLOBAL;
    cfg_wdata <= social_gain;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sample both channels and the register port at the rising edge.
  always @(posedge clk) begin : observe
    pso_request_t seen_req;
    pso_result_t  seen_res;
    if (rst_n) begin
      if (cfg_we) ledger.set_gain(pso_pkg::cfg_reg_t'(cfg_index), cfg_wdata);
      if (in_req.valid && in_req.ready) begin
        seen_req.position      = in_req.position;
        seen_req.velocity      = in_req.velocity;
        seen_req.personal_best = in_req.personal_best;
        seen_req.global_best   = in_req.global_best;
        seen_req.rand_one      = in_req.rand_one;
        seen_req.rand_two      = in_req.rand_two;
        seen_req.lower_limit   = in_req.lower_limit;
        seen_req.upper_limit   = in_req.upper_limit;
        seen_req.speed_limit   = in_req.speed_limit;
        seen_req.last_item     = in_req.last_item;
        ledger.note_request(seen_req);
      end
      if (out_res.valid && out_res.ready) begin
        seen_res.new_position  = out_res.new_position;
        seen_res.new_velocity  = out_res.new_velocity;
        seen_res.speed_clamped = out_res.speed_clamped;
        seen_res.bound_hit     = pso_pkg::hit_t'(out_res.bound_hit);
        seen_res.last_out      = out_res.last_out;
        ledger.check_result(seen_res);
      end
    end
  end

  // Result side: short random stalls, plus one long hold-off when asked.
  initial begin : result_acceptor
    out_res.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_due) begin
        hold_due = 1'b0;
        out_res.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_res.ready <= 1'b0;
        repeat ($urandom_range(0, 2)) @(negedge clk);
      end else begin
        out_res.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("pso_particle_update regression: fail");
    $finish;
  end

  initial begin : stimulus
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = pso_pkg::CFG_GAIN_PERSONAL;
    cfg_wdata            = '0;
    calm                 = 1'b0;
    hold_due             = 1'b0;
    in_req.valid         = 1'b0;
    in_req.position      = '0;
    in_req.velocity      = '0;
    in_req.personal_best = '0;
    in_req.global_best   = '0;
    in_req.rand_one      = '0;
    in_req.rand_two      = '0;
    in_req.lower_limit   = '0;
    in_req.upper_limit   = '0;
    in_req.speed_limit   = '0;
    in_req.last_item     = 1'b0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset gains are 2.0, so rand = 0 leaves the velocity untouched.
    send_request(make_request(0, 0, 0, 0, 0, 0, -10 * ONE, 10 * ONE, ONE, 0));
    send_request(make_request(ONE, ONE / 2, 2 * ONE, 3 * ONE, 16'h8000, 16'hFFFF,
                              -10 * ONE, 10 * ONE, 4 * ONE, 0));
    // clamp both ways, exact limit unclamped
    send_request(make_request(0, 5 * ONE, 0, 0, 0, 0, -10 * ONE, 10 * ONE, ONE, 0));
    send_request(make_request(0, -5 * ONE, 0, 0, 0, 0, -10 * ONE, 10 * ONE, ONE, 0));
    send_request(make_request(0, ONE, 0, 0, 0, 0, -10 * ONE, 10 * ONE, ONE, 0));
    // zero speed limit, with and without a velocity to kill
    send_request(make_request(0, ONE, 0, 0, 0, 0, -10 * ONE, 10 * ONE, 0, 0));
    send_request(make_request(0, 0, 0, 0, 0, 0, -10 * ONE, 10 * ONE, 0, 0));
    // reflections; odd negative velocity halves with floor
    send_request(make_request(9 * ONE, 3 * ONE, 0, 0, 0, 0, -10 * ONE, 10 * ONE,
                              4 * ONE, 0));
    send_request(make_request(-9 * ONE, -3 * ONE - 1, 0, 0, 0, 0, -10 * ONE, 10 * ONE,
                              4 * ONE, 0));
    send_request(make_request(0, -1, 0, 0, 0, 0, 0, 10 * ONE, ONE, 0));
    // inverted bounds, and a reflection that lands past the other bound
    send_request(make_request(0, 0, 0, 0, 0, 0, ONE, -ONE, ONE, 0));
    send_request(make_request(ONE / 2, 4 * ONE, 0, 0, 0, 0, 0, ONE, 8 * ONE, 0));
    // position and velocity saturation
    send_request(make_request(DMAX, DMAX, 0, 0, 0, 0, DMIN, DMAX, SPEED_MAX, 0));
    send_request(make_request(DMIN, DMIN, 0, 0, 0, 0, DMIN, DMAX, SPEED_MAX, 0));
    // difference and pull saturation
    send_request(make_request(DMIN, 0, DMAX, DMAX, 16'hFFFF, 16'hFFFF, DMIN, DMAX,
                              SPEED_MAX, 0));
    send_request(make_request(DMAX, 0, DMIN, DMIN, 16'hFFFF, 16'hFFFF, DMIN, DMAX,
                              SPEED_MAX, 0));
    // overshoot saturates before halving
    send_request(make_request(DMAX, 0, 0, 0, 0, 0, DMIN, DMIN, SPEED_MAX, 0));
    send_request(make_request(DMIN, 0, 0, 0, 0, 0, DMAX, DMAX, SPEED_MAX, 0));
    // small negative pull rounds toward minus infinity
    send_request(make_request(1, 0, 0, 0, 16'h0008, 0, -ONE, ONE, ONE, 0));
    send_request(make_request(-ONE, ONE, DMAX, DMIN, 16'hFFFF, 16'hFFFF, DMIN, DMAX,
                              SPEED_MAX, 1));

    for (int ph = 0; ph < 7; ph++) begin
      drain_results();
      write_gains(16'((phase_personal[ph] < 0) ? $urandom_range(0, 65535)
                                               : phase_personal[ph]),
                  16'((phase_social[ph] < 0) ? $urandom_range(0, 65535)
                                             : phase_social[ph]));
      calm = (ph == 6);
      // stall the result side long enough to back up the pipeline
      if (ph == 0 || ph == 3) hold_due = 1'b1;
      repeat (phase_items[ph]) send_request(random_request());
    end

    drain_results();
    repeat (2 * pso_pkg::STAGES) @(posedge clk);
    if (ledger.errors == 0 && ledger.pending_count() == 0) begin
      $display("pso_particle_update regression: pass");
    end else begin
      $display("pso_particle_update regression: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/pso_pkg.sv
rtl/core/pso_in_if.sv
rtl/core/pso_out_if.sv
rtl/core/pso_pull.sv
rtl/core/pso_particle_update.sv
tb/sv/tb_pso_particle_update.sv
